### hdl/swm_pkg.sv
// ---------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median
// Holds the configuration register layout and the control word that the
// top level broadcasts to every cell of the sorted chain.
// ---------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

    // window_size register
    localparam int          CFG_W     = 7;
    localparam logic [6:0]  WIN_RESET = 7'd3;

    // per-cycle command to the cell chain
    typedef struct packed {
        logic en;   // update cells this cycle
        logic rm;   // remove the oldest entry
        logic ins;  // insert the new sample
    } cell_ctl_t;

endpackage

`default_nettype wire

### hdl/swm_cell.sv
// ---------------------------------------------------------------------------
// swm_cell: one slot of the sorted window chain
// Holds one value and its age. Each update takes its own word, a neighbor's
// word or the new sample, so the chain stays in ascending order.
// ---------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
    parameter int INDEX  = 0,
    parameter int SW     = 16,
    parameter int AGE_W  = 6,
    parameter int FILL_W = 7
) (
    input  wire                      clk,
    input  swm_pkg::cell_ctl_t       ctl,
    input  wire signed [SW-1:0]      sample,
    input  wire        [FILL_W-1:0]  fill,
    input  wire        [AGE_W-1:0]   drop_idx,
    input  wire signed [SW-1:0]      left_val,
    input  wire        [AGE_W-1:0]   left_age,
    input  wire                      left_le,
    input  wire signed [SW-1:0]      right_val,
    input  wire        [AGE_W-1:0]   right_age,
    input  wire                      right_le,
    output logic signed [SW-1:0]     val,
    output logic       [AGE_W-1:0]   age,
    output logic                     le,
    output logic                     oldest
);
    import swm_pkg::*;

    logic signed [SW-1:0]    val_reg, val_next;
    logic        [AGE_W-1:0] age_reg, age_next;
    logic                    valid;
    logic [FILL_W-1:0]       fill_m1;
    logic                    below_self, below_left;
    logic signed [SW-1:0]    r_self_val, r_left_val;
    logic        [AGE_W-1:0] r_self_age, r_left_age;
    logic                    rle_self, rle_left;

    assign valid   = FILL_W'(INDEX) < fill;
    assign fill_m1 = fill - 1'b1;
    assign le      = valid && (val_reg <= sample);
    assign oldest  = valid && (age_reg == fill_m1[AGE_W-1:0]);
    assign val     = val_reg;
    assign age     = age_reg;

    // view of the chain with the dropped entry squeezed out
    assign below_self = !ctl.rm || (AGE_W'(INDEX) < drop_idx);
    assign below_left = !ctl.rm || (AGE_W'(INDEX) <= drop_idx);
    assign r_self_val = below_self ? val_reg : right_val;
    assign r_self_age = below_self ? age_reg : right_age;
    assign rle_self   = below_self ? le      : right_le;
    assign r_left_val = below_left ? left_val : val_reg;
    assign r_left_age = below_left ? left_age : age_reg;
    assign rle_left   = below_left ? left_le  : le;

    always_comb
    begin
        val_next = r_self_val;
        age_next = r_self_age;
        if (ctl.ins)
        begin
            if (rle_self)
            begin
                age_next = r_self_age + 1'b1;
            end
            else if ((INDEX == 0) || rle_left)
            begin
                val_next = sample;
                age_next = '0;
            end
            else
            begin
                val_next = r_left_val;
                age_next = r_left_age + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

endmodule

`default_nettype wire

### hdl/sliding_window_median.sv
// ---------------------------------------------------------------------------
// sliding_window_median: streaming median over the last window_size samples
// Sorted chain of cells with age tags; emits twice the median per sample once full.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, sample, restart): one word per sample.
//    restart empties the window before its sample is taken.
//  - Output channel (out_valid/out_ready, median_doubled): twice the median,
//    one fraction bit. No word while the window is still filling.
//  - Config channel (cfg_valid/cfg_ready, cfg_data): window_size, always
//    ready. Write only while idle; 0 acts as 1, values above WINDOW_MAX
//    saturate. Restart after a change is expected.
//  - Throughput: one sample per cycle while the output drains and no drop
//    sequence runs. Each sample takes one chain update: once full, the cell
//    row drops the oldest entry and inserts the new one together. A window
//    shrunk without restart first drops the surplus, one entry per cycle.
//  - Result path: the chain updates at the accepting edge, then the median
//    select and add are registered into the output word once its slot frees.
//  - Reset: window_size = 3, window empty, no word pending. Cell contents
//    are not cleared; the fill count alone marks which cells hold data.
//  - Stall: a result waits in the output register; one more sample can be
//    taken behind it, then in_ready drops until out_ready frees the slot.
// ---------------------------------------------------------------------------
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW_MAX   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [swm_pkg::CFG_W-1:0]     cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire signed [SAMPLE_WIDTH-1:0] sample,
    input  wire                          restart,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [SAMPLE_WIDTH:0] median_doubled
);
    import swm_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);

    // registers
    logic [CFG_W-1:0]        ws_reg;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic                    busy_reg, busy_next;
    logic signed [SW-1:0]    held_reg;
    logic                    pend_reg, pend_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SW:0]      out_data_reg, out_data_next;

    // control
    logic [FILL_W-1:0]       w_eff;
    logic                    accept, step, res_due, out_can_load, out_load;
    logic [FILL_W-1:0]       fill_base;
    logic signed [SW-1:0]    cur_sample;
    cell_ctl_t               ctl;
    logic [AGE_W-1:0]        drop_idx;
    logic [FILL_W-1:0]       mid_hi, mid_lo;
    logic signed [SW-1:0]    mid_a, mid_b;

    // cell row
    logic signed [SW-1:0]    cell_val [WINDOW_MAX];
    logic        [AGE_W-1:0] cell_age [WINDOW_MAX];
    logic                    cell_le  [WINDOW_MAX];
    logic                    cell_old [WINDOW_MAX];

    assign cfg_ready = 1'b1;

    // effective window length
    always_comb
    begin
        if (ws_reg == '0)
            w_eff = FILL_W'(1);
        else if (int'(ws_reg) > WINDOW_MAX)
            w_eff = FILL_W'(WINDOW_MAX);
        else
            w_eff = FILL_W'(ws_reg);
    end

    // handshake
    assign out_can_load = !out_valid_reg || out_ready;
    assign out_load     = pend_reg && out_can_load;
    assign in_ready     = !busy_reg && (!pend_reg || out_can_load);
    assign accept       = in_valid && in_ready;
    assign step         = accept || busy_reg;
    assign cur_sample   = busy_reg ? held_reg : sample;
    assign fill_base    = (accept && restart) ? '0 : fill_reg;

    // chain command: insert while filling, drop+insert when full,
    // drop alone while the window is over size
    always_comb
    begin
        ctl       = '0;
        fill_next = fill_reg;
        busy_next = busy_reg;
        res_due   = 1'b0;
        if (step)
        begin
            ctl.en = 1'b1;
            if (fill_base < w_eff)
            begin
                ctl.ins   = 1'b1;
                fill_next = fill_base + 1'b1;
                res_due   = (fill_base + 1'b1) == w_eff;
                busy_next = 1'b0;
            end
            else if (fill_base == w_eff)
            begin
                ctl.rm    = 1'b1;
                ctl.ins   = 1'b1;
                fill_next = fill_base;
                res_due   = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                ctl.rm    = 1'b1;
                fill_next = fill_base - 1'b1;
                busy_next = 1'b1;
            end
        end
    end

    // position of the oldest entry (one-hot to binary)
    always_comb
    begin
        drop_idx = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (cell_old[i])
                drop_idx = drop_idx | AGE_W'(i);
        end
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++)
        begin : g_cell
            logic signed [SW-1:0]    lv, rv;
            logic        [AGE_W-1:0] la, ra;
            logic                    ll, rl;

            if (g == 0)
            begin : g_left_edge
                assign lv = '0;
                assign la = '0;
                assign ll = 1'b0;
            end
            else
            begin : g_left
                assign lv = cell_val[g-1];
                assign la = cell_age[g-1];
                assign ll = cell_le[g-1];
            end

            if (g == WINDOW_MAX - 1)
            begin : g_right_edge
                assign rv = '0;
                assign ra = '0;
                assign rl = 1'b0;
            end
            else
            begin : g_right
                assign rv = cell_val[g+1];
                assign ra = cell_age[g+1];
                assign rl = cell_le[g+1];
            end

            swm_cell #(
                .INDEX  (g),
                .SW     (SW),
                .AGE_W  (AGE_W),
                .FILL_W (FILL_W)
            ) u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .sample    (cur_sample),
                .fill      (fill_base),
                .drop_idx  (drop_idx),
                .left_val  (lv),
                .left_age  (la),
                .left_le   (ll),
                .right_val (rv),
                .right_age (ra),
                .right_le  (rl),
                .val       (cell_val[g]),
                .age       (cell_age[g]),
                .le        (cell_le[g]),
                .oldest    (cell_old[g])
            );
        end
    endgenerate

    // middle taps; fixed between config writes
    assign mid_hi = w_eff >> 1;
    assign mid_lo = w_eff[0] ? mid_hi : (mid_hi - 1'b1);
    assign mid_a  = cell_val[mid_hi[AGE_W-1:0]];
    assign mid_b  = cell_val[mid_lo[AGE_W-1:0]];

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_load)
        begin
            pend_next      = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = {mid_a[SW-1], mid_a} + {mid_b[SW-1], mid_b};
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (step && res_due)
            pend_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= WIN_RESET;
            fill_reg      <= '0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                ws_reg <= cfg_data;
            fill_reg      <= fill_next;
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_reg <= sample;
        out_data_reg <= out_data_next;
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = out_data_reg;

    // checks
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ready)
        else $error("input taken during drop sequence");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= WINDOW_MAX)
        else $error("fill count above window capacity");

    a_busy_oversize: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (fill_reg >= w_eff))
        else $error("drop sequence with window not over size");

    a_pend_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid)
        else $error("pending result not presented");

    a_full_after_replace: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ctl.rm && ctl.ins) |=> (fill_reg == w_eff))
        else $error("window not full after replace");

endmodule

`default_nettype wire
